>>> hdl/spi_adc_averaging_reader_unit_assert.svh
// Assertion macros for the averaging converter reader.
// Included by the checker module; depends on a clock i_clk and reset i_rst_n in scope.
`ifndef SPI_ADC_AVERAGING_READER_UNIT_ASSERT_SVH
`define SPI_ADC_AVERAGING_READER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SADR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sadr assertion failed");

// Next-cycle implication.
`define SADR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sadr assertion failed");

`endif

>>> hdl/sadr_pkg.sv
// Shared types and constants for the averaging converter reader.
// No dependencies; used by the reader and its submodules through scoped names.
package sadr_pkg;

    localparam int READ_BITS_DEF = 14;

    localparam int CNT_W   = 10;   // avg_count / gap_ticks
    localparam int SUM_W   = 24;
    localparam int AVG_W   = 14;
    localparam int WHOLE_W = 15;
    localparam int FRAC_W  = 12;
    localparam int CHAN_W  = 3;
    localparam int SCALE_W = 13;
    localparam int PROD_W  = AVG_W + SCALE_W;
    localparam int IDX_W   = 2;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 48;

    localparam logic [SCALE_W-1:0] MV_SCALE   = 13'd5000;
    localparam logic [CNT_W-1:0]   AVG_MAX    = 10'd1000;
    localparam logic [CNT_W-1:0]   GAP_MAX    = 10'd999;
    localparam logic [1:0]         CMD_PREFIX = 2'b11;   // start + single-ended

    localparam logic [IDX_W-1:0] REG_AVG_COUNT = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAP_TICKS = 2'd1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_NULL,
        PH_READ,
        PH_GAP
    } t_phase;

    typedef struct packed {
        logic cs_n;
        logic sck;
        logic mosi;
        logic busy;
    } t_spi_io;

endpackage

>>> hdl/spi_adc_averaging_reader_unit.sv
// Averaging reader for a serial converter: one request per serial half-period tick.
// Uses sadr_pkg, sadr_seq, sadr_div and sadr_mul.
//
// Usage:
//   Each request on s_axis is one tick of the serial link: start_req, channel and the
//   miso bit sampled this tick. For every request one response leaves on m_axis with
//   cs_n, sck, mosi, busy_res, done_res and the held result (average code, whole
//   millivolts and 1/4096 fraction), all taken from the state before the tick.
//   Config: i_cfg_we writes register i_cfg_idx (0 avg_count, 1 gap_ticks); values
//   outside the legal range saturate, other indexes are dropped.
// Timing:
//   A request's response is registered and appears the next clock. The request that
//   closes a reading starts a bit-serial divide and then a bit-serial multiply by
//   5000; s_axis_tready stays low until the result registers load, and done_res
//   rides the next response. The output register is the only buffer: a request is
//   taken while a response waits if m_axis_tready takes that response in the same
//   clock.
// Reset: synchronous, active low; the link goes idle, results and done clear,
//   avg_count and gap_ticks return to 1. A stalled receiver holds m_axis_tdata.
module spi_adc_averaging_reader_unit #(
    parameter int READ_BITS = sadr_pkg::READ_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sadr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [sadr_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_req[0], channel[3:1], miso[4], zero pad[7:5]
    input  logic [sadr_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // cs_n[0], sck[1], mosi[2], busy_res[3], done_res[4], avg_code[18:5],
    // mv_whole[33:19], mv_frac[45:34], zero pad[47:46]
    output logic [sadr_pkg::OUT_W-1:0]    m_axis_tdata
);
    localparam int AW = sadr_pkg::AVG_W;
    localparam int WW = sadr_pkg::WHOLE_W;
    localparam int FW = sadr_pkg::FRAC_W;
    localparam int PAD_W = sadr_pkg::OUT_W - 5 - AW - WW - FW;

    sadr_pkg::t_spi_io           w_io;
    logic                        w_acc;
    logic                        w_fin;
    logic [sadr_pkg::SUM_W-1:0]  w_sum;
    logic [sadr_pkg::CNT_W-1:0]  w_count;
    logic                        w_div_done;
    logic [sadr_pkg::SUM_W-1:0]  w_quot;
    logic                        w_mul_done;
    logic [sadr_pkg::PROD_W-1:0] w_prod;

    logic                        r_m_valid;
    logic [sadr_pkg::OUT_W-1:0]  r_m_data;
    logic                        r_calc;
    logic                        r_done;
    logic [AW-1:0]               r_avg;
    logic [WW-1:0]               r_whole;
    logic [FW-1:0]               r_frac;

    assign s_axis_tready = ~r_calc & (~r_m_valid | m_axis_tready);
    assign w_acc         = s_axis_tvalid & s_axis_tready;

    sadr_seq #(
        .READ_BITS(READ_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_acc),
        .i_start    (s_axis_tdata[0]),
        .i_chan     (s_axis_tdata[3:1]),
        .i_miso     (s_axis_tdata[4]),
        .o_io       (w_io),
        .o_fin      (w_fin),
        .o_sum      (w_sum),
        .o_count    (w_count)
    );

    sadr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_fin),
        .i_dividend (w_sum),
        .i_divisor  (w_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    sadr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_done),
        .i_avg   (w_quot[AW-1:0]),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_calc    <= 1'b0;
            r_done    <= 1'b0;
            r_avg     <= '0;
            r_whole   <= '0;
            r_frac    <= '0;
        end else begin
            if (w_acc) begin
                r_m_valid <= 1'b1;
                r_done    <= 1'b0;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_fin) begin
                r_calc <= 1'b1;
            end
            if (w_mul_done) begin
                r_calc  <= 1'b0;
                r_done  <= 1'b1;
                r_avg   <= w_quot[AW-1:0];
                r_whole <= w_prod[FW +: WW];
                r_frac  <= w_prod[FW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_m_data <= {{PAD_W{1'b0}}, r_frac, r_whole, r_avg, r_done,
                         w_io.busy, w_io.mosi, w_io.sck, w_io.cs_n};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
endmodule

>>> hdl/sadr_div.sv
// Bit-serial restoring divider: sum / count, one quotient bit per clock.
// Depends on sadr_pkg.
module sadr_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sadr_pkg::SUM_W-1:0]   i_dividend,
    input  logic [sadr_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [sadr_pkg::SUM_W-1:0]   o_quot
);
    localparam int SW = sadr_pkg::SUM_W;
    localparam int DW = sadr_pkg::CNT_W;
    localparam int KW = $clog2(SW + 1);

    logic [SW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;

    assign w_trial = {r_rem, r_q[SW-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> hdl/sadr_mul.sv
// Bit-serial shift-add multiplier: average code times the millivolt scale.
// Depends on sadr_pkg.
module sadr_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sadr_pkg::AVG_W-1:0]    i_avg,
    output logic                          o_done,
    output logic [sadr_pkg::PROD_W-1:0]   o_prod
);
    localparam int AW = sadr_pkg::AVG_W;
    localparam int PW = sadr_pkg::PROD_W;
    localparam int KW = $clog2(AW + 1);

    logic [PW-1:0] r_p;   // upper: partial sum, lower: multiplier bits left
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [PW-AW:0] w_add;

    assign w_add = {1'b0, r_p[PW-1:AW]}
                 + (r_p[0] ? {1'b0, sadr_pkg::MV_SCALE} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(AW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_p <= {{(PW-AW){1'b0}}, i_avg};
        end else if (r_busy) begin
            r_p <= {w_add, r_p[AW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
endmodule

>>> hdl/sadr_seq.sv
// Serial-link sequencer: command shift-out, data shift-in, sum, gaps, config registers.
// Depends on sadr_pkg.
module sadr_seq #(
    parameter int READ_BITS = sadr_pkg::READ_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sadr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [sadr_pkg::CNT_W-1:0]    i_cfg_data,
    input  logic                          i_step,
    input  logic                          i_start,
    input  logic [sadr_pkg::CHAN_W-1:0]   i_chan,
    input  logic                          i_miso,
    output sadr_pkg::t_spi_io             o_io,
    output logic                          o_fin,
    output logic [sadr_pkg::SUM_W-1:0]    o_sum,
    output logic [sadr_pkg::CNT_W-1:0]    o_count
);
    localparam int BW = $clog2(2 * READ_BITS);
    localparam int CW = sadr_pkg::CNT_W;
    localparam int AW = sadr_pkg::AVG_W;
    localparam int SW = sadr_pkg::SUM_W;
    localparam logic [BW-1:0] LAST_READ = BW'(2 * READ_BITS - 1);

    sadr_pkg::t_phase r_phase, n_phase;
    logic [BW-1:0] r_bc, n_bc;
    logic [AW-1:0] r_shift, n_shift;
    logic [SW-1:0] r_sum, n_sum;
    logic [CW-1:0] r_reps, n_reps;
    logic [CW-1:0] r_gap, n_gap;
    logic [sadr_pkg::CHAN_W-1:0] r_chan, n_chan;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_avg_count;
    logic [CW-1:0] r_gap_ticks;

    logic [4:0]    w_cmd;
    logic [CW-1:0] w_gap_inc;
    logic          w_active;
    logic          w_fin;

    assign w_cmd     = {sadr_pkg::CMD_PREFIX, r_chan};
    assign w_gap_inc = r_gap + 1'b1;
    assign w_active  = (r_phase == sadr_pkg::PH_CMD) || (r_phase == sadr_pkg::PH_NULL)
                    || (r_phase == sadr_pkg::PH_READ);

    always_comb begin
        o_io.cs_n = ~w_active;
        o_io.sck  = w_active & r_bc[0];
        o_io.busy = (r_phase != sadr_pkg::PH_IDLE);
        o_io.mosi = 1'b0;
        if ((r_phase == sadr_pkg::PH_CMD) && (r_bc[BW-1:1] <= (BW-1)'(4))) begin
            o_io.mosi = w_cmd[3'(3'd4 - r_bc[3:1])];
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_shift = r_shift;
        n_sum   = r_sum;
        n_reps  = r_reps;
        n_gap   = r_gap;
        n_chan  = r_chan;
        n_count = r_count;
        w_fin   = 1'b0;
        case (r_phase)
            sadr_pkg::PH_IDLE: begin
                if (i_start) begin
                    n_chan  = i_chan;
                    n_count = r_avg_count;
                    n_reps  = r_avg_count;
                    n_sum   = '0;
                    n_shift = '0;
                    n_bc    = '0;
                    n_phase = sadr_pkg::PH_CMD;
                end
            end
            sadr_pkg::PH_CMD: begin
                if (r_bc >= BW'(9)) begin
                    n_bc    = '0;
                    n_phase = sadr_pkg::PH_NULL;
                end else begin
                    n_bc = r_bc + 1'b1;
                end
            end
            sadr_pkg::PH_NULL: begin
                if (r_bc >= BW'(3)) begin
                    n_bc    = '0;
                    n_shift = '0;
                    n_phase = sadr_pkg::PH_READ;
                end else begin
                    n_bc = r_bc + 1'b1;
                end
            end
            sadr_pkg::PH_READ: begin
                if (!r_bc[0]) begin
                    n_shift = {r_shift[AW-2:0], i_miso};
                end
                if (r_bc >= LAST_READ) begin
                    n_sum = r_sum + {{(SW-AW){1'b0}}, n_shift};
                    if (r_reps != '0) begin
                        n_reps = r_reps - 1'b1;
                    end
                    n_gap   = '0;
                    n_bc    = '0;
                    n_phase = sadr_pkg::PH_GAP;
                end else begin
                    n_bc = r_bc + 1'b1;
                end
            end
            sadr_pkg::PH_GAP: begin
                n_gap = w_gap_inc;
                if (w_gap_inc >= r_gap_ticks) begin
                    n_gap = '0;
                    if (r_reps == '0) begin
                        w_fin   = 1'b1;
                        n_phase = sadr_pkg::PH_IDLE;
                    end else begin
                        n_bc    = '0;
                        n_phase = sadr_pkg::PH_CMD;
                    end
                end
            end
            default: begin
                n_phase = sadr_pkg::PH_IDLE;
                n_bc    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sadr_pkg::PH_IDLE;
            r_bc    <= '0;
            r_shift <= '0;
            r_sum   <= '0;
            r_reps  <= '0;
            r_gap   <= '0;
            r_chan  <= '0;
            r_count <= CW'(1);
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_shift <= n_shift;
            r_sum   <= n_sum;
            r_reps  <= n_reps;
            r_gap   <= n_gap;
            r_chan  <= n_chan;
            r_count <= n_count;
        end
    end

    // config writes saturate into range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_count <= CW'(1);
            r_gap_ticks <= CW'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == sadr_pkg::REG_AVG_COUNT) begin
                if (i_cfg_data == '0) begin
                    r_avg_count <= CW'(1);
                end else if (i_cfg_data > sadr_pkg::AVG_MAX) begin
                    r_avg_count <= sadr_pkg::AVG_MAX;
                end else begin
                    r_avg_count <= i_cfg_data;
                end
            end else if (i_cfg_idx == sadr_pkg::REG_GAP_TICKS) begin
                if (i_cfg_data == '0) begin
                    r_gap_ticks <= CW'(1);
                end else if (i_cfg_data > sadr_pkg::GAP_MAX) begin
                    r_gap_ticks <= sadr_pkg::GAP_MAX;
                end else begin
                    r_gap_ticks <= i_cfg_data;
                end
            end
        end
    end

    assign o_fin   = w_fin & i_step;
    assign o_sum   = r_sum;
    assign o_count = r_count;
endmodule

>>> hdl/sadr_chk.sv
// Port-level checker for the averaging converter reader, bound to the top level.
// Depends on spi_adc_averaging_reader_unit_assert.svh.
`include "spi_adc_averaging_reader_unit_assert.svh"

module sadr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    `SADR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // a finished reading is reported in an idle tick
    `SADR_ASSERT_NOW(a_done_idle, m_axis_tvalid && m_axis_tdata[4], !m_axis_tdata[3])
    // no clock edges while deselected
    `SADR_ASSERT_NOW(a_sck_cs, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[1])
    `SADR_ASSERT_NOW(a_mosi_cs, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[0] && m_axis_tdata[3])
endmodule

bind spi_adc_averaging_reader_unit sadr_chk u_sadr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/tb_spi_adc_averaging_reader_unit.sv
// Self-checking testbench for spi_adc_averaging_reader_unit: sends serial-link ticks,
// predicts every response with a tick model of the reader and compares field by field.
// Depends on sadr_pkg and the RTL in hdl/.

typedef struct packed {
    logic [2:0] pad;
    logic       miso;
    logic [2:0] channel;
    logic       start_req;
} tick_req_t;

typedef struct packed {
    logic [sadr_pkg::OUT_W-47:0]   pad;
    logic [sadr_pkg::FRAC_W-1:0]   mv_frac;
    logic [sadr_pkg::WHOLE_W-1:0]  mv_whole;
    logic [sadr_pkg::AVG_W-1:0]    avg_code;
    logic                          done_res;
    logic                          busy_res;
    logic                          mosi;
    logic                          sck;
    logic                          cs_n;
} link_word_t;

class adc_link_scoreboard;
    logic [9:0]        avg_count_reg;
    logic [9:0]        gap_ticks_reg;
    sadr_pkg::t_phase  phase;
    logic [4:0]        bit_count;
    logic [13:0]       shift_in;
    logic [23:0]       sample_sum;
    logic [9:0]        reps_left;
    logic [9:0]        gap_count;
    logic [9:0]        held_count;
    logic [2:0]        held_channel;
    logic [13:0]       res_avg;
    logic [14:0]       res_whole;
    logic [11:0]       res_frac;
    logic              done_flag;
    link_word_t        link_words_due[$];
    int unsigned       ticks;
    int unsigned       readings;
    int unsigned       checked;
    int unsigned       mismatches;

    function new();
        avg_count_reg = 10'd1;
        gap_ticks_reg = 10'd1;
        phase         = sadr_pkg::PH_IDLE;
        bit_count     = '0;
        shift_in      = '0;
        sample_sum    = '0;
        reps_left     = '0;
        gap_count     = '0;
        held_count    = 10'd1;
        held_channel  = '0;
        res_avg       = '0;
        res_whole     = '0;
        res_frac      = '0;
        done_flag     = 1'b0;
        ticks         = 0;
        readings      = 0;
        checked       = 0;
        mismatches    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] data);
        case (idx)
            sadr_pkg::REG_AVG_COUNT: begin
                avg_count_reg = (data == 0) ? 10'd1 :
                                (data > sadr_pkg::AVG_MAX) ? sadr_pkg::AVG_MAX : data;
            end
            sadr_pkg::REG_GAP_TICKS: begin
                gap_ticks_reg = (data == 0) ? 10'd1 :
                                (data > sadr_pkg::GAP_MAX) ? sadr_pkg::GAP_MAX : data;
            end
            default: ;
        endcase
    endfunction

    function bit is_idle();
        return phase == sadr_pkg::PH_IDLE;
    endfunction

    function int unsigned pending();
        return link_words_due.size();
    endfunction

    // Response comes from the state before the tick; state advances afterwards.
    function void predict_tick(tick_req_t req);
        link_word_t  w;
        logic        link_on;
        logic [4:0]  cmd_word;
        int          cmd_idx;
        logic [23:0] quot;
        logic [26:0] prod;
        w        = '0;
        link_on  = (phase == sadr_pkg::PH_CMD) || (phase == sadr_pkg::PH_NULL) ||
                   (phase == sadr_pkg::PH_READ);
        cmd_word = {sadr_pkg::CMD_PREFIX, held_channel};
        cmd_idx  = bit_count >> 1;
        w.cs_n     = !link_on;
        w.sck      = link_on & bit_count[0];
        w.mosi     = (phase == sadr_pkg::PH_CMD && cmd_idx <= 4) ? cmd_word[4 - cmd_idx] : 1'b0;
        w.busy_res = (phase != sadr_pkg::PH_IDLE);
        w.done_res = done_flag;
        w.avg_code = res_avg;
        w.mv_whole = res_whole;
        w.mv_frac  = res_frac;
        link_words_due.push_back(w);
        ticks++;
        if (done_flag)
            readings++;

        done_flag = 1'b0;
        case (phase)
            sadr_pkg::PH_IDLE: begin
                if (req.start_req) begin
                    held_channel = req.channel;
                    held_count   = avg_count_reg;
                    reps_left    = avg_count_reg;
                    sample_sum   = '0;
                    shift_in     = '0;
                    bit_count    = '0;
                    phase        = sadr_pkg::PH_CMD;
                end
            end
            sadr_pkg::PH_CMD: begin
                if (bit_count >= 9) begin
                    bit_count = '0;
                    phase     = sadr_pkg::PH_NULL;
                end else begin
                    bit_count++;
                end
            end
            sadr_pkg::PH_NULL: begin
                if (bit_count >= 3) begin
                    bit_count = '0;
                    shift_in  = '0;
                    phase     = sadr_pkg::PH_READ;
                end else begin
                    bit_count++;
                end
            end
            sadr_pkg::PH_READ: begin
                if (!bit_count[0])
                    shift_in = {shift_in[12:0], req.miso};
                if (bit_count >= 2 * sadr_pkg::READ_BITS_DEF - 1) begin
                    sample_sum = sample_sum + {10'd0, shift_in};
                    if (reps_left > 0)
                        reps_left--;
                    gap_count = '0;
                    bit_count = '0;
                    phase     = sadr_pkg::PH_GAP;
                end else begin
                    bit_count++;
                end
            end
            sadr_pkg::PH_GAP: begin
                gap_count++;
                if (gap_count >= gap_ticks_reg) begin
                    gap_count = '0;
                    if (reps_left == 0) begin
                        quot      = sample_sum / {14'd0, (held_count == 0) ? 10'd1 : held_count};
                        res_avg   = quot[13:0];
                        prod      = 27'(res_avg) * 27'(sadr_pkg::MV_SCALE);
                        res_whole = prod[26:12];
                        res_frac  = prod[11:0];
                        done_flag = 1'b1;
                        phase     = sadr_pkg::PH_IDLE;
                    end else begin
                        bit_count = '0;
                        phase     = sadr_pkg::PH_CMD;
                    end
                end
            end
            default: begin
                phase     = sadr_pkg::PH_IDLE;
                bit_count = '0;
            end
        endcase
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH at response %0d: %s", checked, msg);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            flag($sformatf("%s expected %0d got %0d", field, want, got));
    endfunction

    function void check_link_word(logic [sadr_pkg::OUT_W-1:0] data);
        link_word_t got;
        link_word_t want;
        got = data;
        checked++;
        if (link_words_due.size() == 0) begin
            flag($sformatf("response with none outstanding, data %h", data));
            return;
        end
        want = link_words_due.pop_front();
        compare_field("cs_n",     16'(want.cs_n),     16'(got.cs_n));
        compare_field("sck",      16'(want.sck),      16'(got.sck));
        compare_field("mosi",     16'(want.mosi),     16'(got.mosi));
        compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
        compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
        compare_field("avg_code", 16'(want.avg_code), 16'(got.avg_code));
        compare_field("mv_whole", 16'(want.mv_whole), 16'(got.mv_whole));
        compare_field("mv_frac",  16'(want.mv_frac),  16'(got.mv_frac));
    endfunction
endclass

module tb_spi_adc_averaging_reader_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import sadr_pkg::*;

    typedef enum {MISO_ZEROS, MISO_ONES, MISO_RANDOM} miso_mode_t;

    localparam logic [IDX_W-1:0] REG_SPARE_2   = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_3   = 2'd3;
    localparam int               SETTLE_CYCLES = 60;
    localparam int               RANDOM_TICKS  = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = '0;
    logic [CNT_W-1:0]   i_cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata = '0;  // start_req[0], channel[3:1], miso[4], pad[7:5]
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // cs_n[0], sck[1], mosi[2], busy_res[3], done_res[4], avg_code[18:5],
    // mv_whole[33:19], mv_frac[45:34], pad[47:46]
    logic [OUT_W-1:0]   m_axis_tdata;

    adc_link_scoreboard sb = new();
    bit                 tx_steady = 1'b0;
    bit                 rx_steady = 1'b0;
    int unsigned        reg_writes = 0;

    always #6 i_clk = ~i_clk;

    spi_adc_averaging_reader_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic logic miso_bit(miso_mode_t mode);
        case (mode)
            MISO_ZEROS: return 1'b0;
            MISO_ONES:  return 1'b1;
            default:    return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_tick(input logic start, input logic [2:0] chan, input logic miso);
        tick_req_t   req;
        int unsigned hold;
        req           = '0;
        req.start_req = start;
        req.channel   = chan;
        req.miso      = miso;
        hold          = tx_steady ? 0 : $urandom_range(0, 6);
        if (hold != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        sb.predict_tick(req);
    endtask

    task automatic idle_ticks(input int unsigned count);
        repeat (count) send_tick(1'b0, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    // noisy: random start requests and channels while busy, which must be ignored
    task automatic run_reading(input logic [2:0] chan, input miso_mode_t mode, input bit noisy);
        send_tick(1'b1, chan, miso_bit(mode));
        while (!sb.is_idle()) begin
            if (noisy)
                send_tick(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), miso_bit(mode));
            else
                send_tick(1'b0, chan, miso_bit(mode));
        end
    endtask

    // drain all responses, then leave time for the divide/multiply to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        reg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            int unsigned stall;
            stall = rx_steady ? 0 : $urandom_range(0, 6);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
            sb.check_link_word(m_axis_tdata);
        end
    end

    initial begin
        int unsigned random_goal;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values, then defaults (one conversion, one gap tick)
        idle_ticks(3);
        run_reading(3'd0, MISO_ONES, 1'b0);
        run_reading(3'd7, MISO_ZEROS, 1'b1);   // started in the done tick
        run_reading(3'd5, MISO_RANDOM, 1'b1);
        idle_ticks(2);
        settle();

        // saturation: count 0 -> 1, gap 1023 -> 999; spare indexes do nothing
        write_reg(REG_AVG_COUNT, 10'd0);
        write_reg(REG_GAP_TICKS, 10'h3FF);
        write_reg(REG_SPARE_2, 10'h3FF);
        write_reg(REG_SPARE_3, 10'd0);
        run_reading(3'd2, MISO_RANDOM, 1'b0);
        idle_ticks(1);
        settle();

        // full-scale codes on every conversion: largest average and product
        write_reg(REG_AVG_COUNT, 10'd3);
        write_reg(REG_GAP_TICKS, 10'd0);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        run_reading(3'd6, MISO_ONES, 1'b0);
        idle_ticks(1);
        settle();

        random_goal = sb.ticks + RANDOM_TICKS;
        while (sb.ticks < random_goal) begin
            settle();
            write_reg(REG_AVG_COUNT, ($urandom_range(0, 9) == 0) ? 10'd0 :
                                     10'($urandom_range(1, 4)));
            write_reg(REG_GAP_TICKS, ($urandom_range(0, 9) == 0) ? 10'd0 :
                                     10'($urandom_range(1, 10)));
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          10'($urandom_range(0, 1023)));
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 2)) begin
                run_reading(3'($urandom_range(0, 7)), miso_mode_t'($urandom_range(0, 2)),
                            1'($urandom_range(0, 1)));
                idle_ticks($urandom_range(0, 3));
            end
        end
        idle_ticks(2);
        settle();

        $display("Covered %0d link ticks, %0d averaged readings, %0d register writes",
                 sb.ticks, sb.readings, reg_writes);
        $display("Responses checked: %0d, mismatches: %0d", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("spi_adc_averaging_reader_unit test passed");
        else
            $display("spi_adc_averaging_reader_unit test failed");
        $finish;
    end

    initial begin
        #40ms;
        $display("Timeout with %0d responses outstanding", sb.pending());
        $display("spi_adc_averaging_reader_unit test failed");
        $finish;
    end
endmodule
